// ===== src/rcr_pkg.sv =====
package rcr_pkg;

    // Default history length (colours kept)
    localparam int HISTORY_DEPTH_DEF = 16;

    localparam int COLOR_W = 24;
    localparam int COORD_W = 8;
    localparam int SQ_W    = 2 * COORD_W;    // one squared offset
    localparam int D2_W    = SQ_W + 1;       // dx*dx + dy*dy
    localparam int ROOT_W  = 9;              // rounded distance, at most 361

    // func codes
    localparam logic FUNC_PUSH  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef struct packed {
        logic               func;
        logic [COLOR_W-1:0] new_color;
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic               explode;
    } in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               index_clamped;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic push;        // write colour into history at oldest slot
        logic load;        // capture pixel request
        logic square;      // dx*dx + dy*dy, seed the root search
        logic root_step;   // one bit of the square root
        logic round;       // round to nearest
        logic index;       // history slot and clamp flag
        logic deliver;     // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic root_last;   // current root step is the final bit
        logic out_free;    // output register can take a result
    } sts_t;

endpackage

// ===== src/rcr_ctrl.sv =====
module rcr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_func,
    output logic          s_ready,
    input  rcr_pkg::sts_t sts,
    output rcr_pkg::cmd_t cmd
);
    import rcr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_ROUND,
        ST_INDEX,
        ST_READ,
        ST_SEND
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_func == FUNC_PIXEL) begin
                        cmd.load   = 1'b1;
                        state_next = ST_SQUARE;
                    end else begin
                        cmd.push   = 1'b1;
                    end
                end
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (sts.root_last) begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_INDEX;
            end
            ST_INDEX: begin
                cmd.index  = 1'b1;
                state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (sts.out_free) begin
                    cmd.deliver = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/rcr_datapath.sv =====
module rcr_datapath #(
    parameter int HISTORY_DEPTH = rcr_pkg::HISTORY_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  rcr_pkg::in_t  s_data,
    input  rcr_pkg::cmd_t cmd,
    output rcr_pkg::sts_t sts,
    input  logic          m_ready,
    output logic          m_valid,
    output rcr_pkg::out_t m_data
);
    import rcr_pkg::*;

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(HISTORY_DEPTH - 1);
    localparam logic [ROOT_W-1:0] LAST_DIST = ROOT_W'(HISTORY_DEPTH - 1);
    localparam logic [SUM_W-1:0]  DEPTH_S   = SUM_W'(HISTORY_DEPTH);

    // history ring; valid bits stand in for the reset-to-black contents
    logic [COLOR_W-1:0]       hist_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0] hist_vld_reg;
    logic [IDX_W-1:0]         oldest_reg;

    in_t                item_reg;
    logic [D2_W-1:0]    d2_reg;
    logic [ROOT_W-1:0]  root_reg;
    logic [ROOT_W-1:0]  bit_reg;
    logic [IDX_W-1:0]   slot_reg;
    logic               clamped_reg;
    logic [COLOR_W-1:0] rd_data_reg;
    logic               rd_vld_reg;
    logic               m_valid_reg;
    out_t               m_data_reg;

    logic [COORD_W-1:0]  dx, dy;
    logic [SQ_W-1:0]     dx_sq, dy_sq;
    logic [ROOT_W-1:0]   trial;
    logic [2*ROOT_W-1:0] trial_sq;
    logic [2*ROOT_W-1:0] root_sq;
    logic [2*ROOT_W:0]   round_sum;
    logic                clamp;
    logic [IDX_W-1:0]    idx;
    logic [SUM_W-1:0]    slot_sum;
    logic [SUM_W-1:0]    slot_wrap;

    // absolute offsets and squares
    always_comb begin
        dx = (item_reg.pixel_x >= item_reg.point_x) ? item_reg.pixel_x - item_reg.point_x
                                                    : item_reg.point_x - item_reg.pixel_x;
        dy = (item_reg.pixel_y >= item_reg.point_y) ? item_reg.pixel_y - item_reg.point_y
                                                    : item_reg.point_y - item_reg.pixel_y;
        dx_sq = dx * dx;
        dy_sq = dy * dy;
    end

    // one bit of floor(sqrt(d2)) per step, MSB first
    assign trial    = root_reg | bit_reg;
    assign trial_sq = trial * trial;

    // nearest integer: bump when root*root + root < d2
    assign root_sq   = root_reg * root_reg;
    assign round_sum = {1'b0, root_sq} + (2*ROOT_W+1)'(root_reg);

    // history index and ring slot
    always_comb begin
        clamp = (root_reg > LAST_DIST);
        if (clamp) begin
            idx = item_reg.explode ? '0 : LAST_IDX;
        end else begin
            idx = item_reg.explode ? LAST_IDX - root_reg[IDX_W-1:0] : root_reg[IDX_W-1:0];
        end
        slot_sum  = {1'b0, oldest_reg} + {1'b0, idx};
        slot_wrap = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;
    end

    assign sts.root_last = bit_reg[0];
    assign sts.out_free  = !m_valid_reg || m_ready;

    // history memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            hist_mem[oldest_reg] <= s_data.new_color;
        end
        rd_data_reg <= hist_mem[slot_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_vld_reg <= '0;
            oldest_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.push) begin
                hist_vld_reg[oldest_reg] <= 1'b1;
                oldest_reg <= (oldest_reg == LAST_IDX) ? '0 : oldest_reg + 1'b1;
            end
            if (cmd.deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        rd_vld_reg <= hist_vld_reg[slot_reg];
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (cmd.square) begin
            d2_reg   <= {1'b0, dx_sq} + {1'b0, dy_sq};
            root_reg <= '0;
            bit_reg  <= {1'b1, {(ROOT_W-1){1'b0}}};
        end
        if (cmd.root_step) begin
            if (trial_sq <= (2*ROOT_W)'(d2_reg)) begin
                root_reg <= trial;
            end
            bit_reg <= bit_reg >> 1;
        end
        if (cmd.round) begin
            if (round_sum < (2*ROOT_W+1)'(d2_reg)) begin
                root_reg <= root_reg + 1'b1;
            end
        end
        if (cmd.index) begin
            slot_reg    <= slot_wrap[IDX_W-1:0];
            clamped_reg <= clamp;
        end
        if (cmd.deliver) begin
            m_data_reg.pixel_color   <= rd_vld_reg ? rd_data_reg : '0;
            m_data_reg.index_clamped <= clamped_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== src/radial_color_ripple_pixel.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  rcr_pkg::in_t  (push colour or pixel request)
// m_        out        m_valid / m_ready  rcr_pkg::out_t (pixel colour, clamp flag)
//
// A push request completes on accept; pushes can be accepted back to back.
// A pixel request raises m_valid after these steps: squared distance, square root
// one bit per cycle, round, slot, history read, load; the load waits for a free output.
// The next request is taken the cycle after the result is loaded, not before.
// aresetn (sync, active low) clears the ring pointer, the valid bits (history reads
// as black) and the output valid. A stalled m_ready holds the result and the input.
module radial_color_ripple_pixel #(
    parameter int HISTORY_DEPTH = rcr_pkg::HISTORY_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request channel
    input  logic          s_valid,
    output logic          s_ready,
    input  rcr_pkg::in_t  s_data,
    // result channel
    output logic          m_valid,
    input  logic          m_ready,
    output rcr_pkg::out_t m_data
);
    import rcr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: accept, square, root steps, round, index, read, deliver
    rcr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic, colour history ring and output register
    rcr_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
